/* src/bfsc_pkg.sv */
// ----------------------------------------------------------------------------
// bfsc_pkg
// Shared types, codes and helpers for the bit-flag store with find.
// ----------------------------------------------------------------------------
package bfsc_pkg;

  localparam int WORD_BITS  = 64;
  localparam int BIT_SEL_W  = 6;
  localparam int MODE_W     = 3;
  localparam int INDEX_W    = 12;
  localparam int WCOUNT_W   = 7;
  localparam int WSEL_W     = INDEX_W - BIT_SEL_W;

  localparam logic [WCOUNT_W-1:0] WORD_COUNT_RESET = 7'd64;

  typedef logic [WORD_BITS-1:0] flag_word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHECK     = 3'd0,
    MODE_SET       = 3'd1,
    MODE_CLEAR     = 3'd2,
    MODE_FIND      = 3'd3,
    MODE_CLEAR_ALL = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_FIND,
    ST_CLR,
    ST_RESP
  } state_t;

  // priority encoder, lowest set bit wins
  function automatic logic [BIT_SEL_W-1:0] lowest_set(input flag_word_t x);
    logic [BIT_SEL_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = BIT_SEL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/bfsc_in_if.sv */
// ----------------------------------------------------------------------------
// bfsc_in_if
// Request channel: mode, bit index and search value with valid/ready.
// ----------------------------------------------------------------------------
interface bfsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfsc_pkg::MODE_W-1:0]   mode;
  logic [bfsc_pkg::INDEX_W-1:0]  bit_addr;
  logic                          find_value;

  modport source (output valid, mode, bit_addr, find_value, input ready);
  modport sink   (input valid, mode, bit_addr, find_value, output ready);
endinterface

/* src/bfsc_out_if.sv */
// ----------------------------------------------------------------------------
// bfsc_out_if
// Result channel: bit value, found flag and found index with valid/ready.
// ----------------------------------------------------------------------------
interface bfsc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          bit_value;
  logic                          found;
  logic [bfsc_pkg::INDEX_W-1:0]  found_index;

  modport source (output valid, bit_value, found, found_index, input ready);
  modport sink   (input valid, bit_value, found, found_index, output ready);
endinterface

/* src/bitmap_find_set_clear.sv */
// ----------------------------------------------------------------------------
// bitmap_find_set_clear
// Bit-flag store of 64-bit words with check, set, clear, clear-all and a
// circular find of the first bit equal to a search value.
// ----------------------------------------------------------------------------
// The flags live in one single-port synchronous RAM of MAX_WORDS x 64 bits,
// and every request is a walk over that one port, one word per cycle, one
// request at a time. Check, set and clear read the word, then modify/write
// it and answer. Find reads the words in turn, at most the word count n of
// them. Clear-all writes zero to each word in use and then answers.
// Out-of-range and unused requests are answered without a RAM access.
// After reset the block zeroes the first min(MAX_WORDS, 127) words (64 by
// default) before it raises ready; cfg writes are taken throughout.
// A finished word sits in an output register, so the block only waits on the
// result side when a second result is ready before the first was taken.
module bitmap_find_set_clear #(
  parameter int MAX_WORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfsc_pkg::WCOUNT_W-1:0]   cfg_wdata,
  bfsc_in_if.sink                         in_chan,
  bfsc_out_if.source                      out_chan
);

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  // words beyond 127 can never be addressed by a 7-bit count
  localparam int LIM = (MAX_WORDS < 127) ? MAX_WORDS : 127;
  localparam int CW  = bfsc_pkg::WCOUNT_W;
  localparam int BW  = bfsc_pkg::BIT_SEL_W;

  bfsc_pkg::flag_word_t mem [MAX_WORDS];

  bfsc_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]        wc_r;
  logic [CW-1:0]        n_words;
  logic [CW-1:0]        cur_r, cur_nxt;
  logic [CW-1:0]        step_r, step_nxt;
  logic [CW-1:0]        next_word;
  logic [bfsc_pkg::MODE_W-1:0] mode_r;
  logic [BW-1:0]        bit_r;
  logic                 want_r;
  bfsc_pkg::flag_word_t rd_data_r;
  bfsc_pkg::flag_word_t hits;
  bfsc_pkg::flag_word_t bit_mask;
  logic                 hit_any;
  logic                 scan_done;

  logic                 accept;
  logic [bfsc_pkg::WSEL_W-1:0] in_word;
  logic                 in_hit;
  logic                 out_free;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  bfsc_pkg::flag_word_t wr_data;
  logic                 load_out;
  logic                 res_bit, res_found;
  logic [bfsc_pkg::INDEX_W-1:0] res_idx;

  logic                 out_valid_r;
  logic                 out_bit_r;
  logic                 out_found_r;
  logic [bfsc_pkg::INDEX_W-1:0] out_idx_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= bfsc_pkg::WORD_COUNT_RESET;
    end else if (cfg_we) begin
      wc_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (wc_r == '0) begin
      n_words = CW'(1);
    end else if (32'(wc_r) > LIM) begin
      n_words = CW'(LIM);
    end else begin
      n_words = wc_r;
    end
  end

  // ---------------------------------------------------------------- decode
  assign accept    = in_chan.valid && in_chan.ready;
  assign in_word   = in_chan.bit_addr[bfsc_pkg::INDEX_W-1:BW];
  assign in_hit    = {1'b0, in_word} < n_words;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign hits      = want_r ? rd_data_r : ~rd_data_r;
  assign hit_any   = |hits;
  assign scan_done = step_r == n_words;
  assign next_word = (CW'(cur_r + CW'(1)) == n_words) ? '0 : CW'(cur_r + CW'(1));
  assign bit_mask  = bfsc_pkg::flag_word_t'(1) << bit_r;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfsc_pkg::ST_INIT: begin
        if (cur_r == CW'(LIM - 1)) begin
          state_nxt = bfsc_pkg::ST_IDLE;
        end
      end
      bfsc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (bfsc_pkg::mode_t'(in_chan.mode))
            bfsc_pkg::MODE_CHECK,
            bfsc_pkg::MODE_SET,
            bfsc_pkg::MODE_CLEAR:     state_nxt = in_hit ? bfsc_pkg::ST_RMW
                                                         : bfsc_pkg::ST_RESP;
            bfsc_pkg::MODE_FIND:      state_nxt = in_hit ? bfsc_pkg::ST_FIND
                                                         : bfsc_pkg::ST_RESP;
            bfsc_pkg::MODE_CLEAR_ALL: state_nxt = bfsc_pkg::ST_CLR;
            default:                  state_nxt = bfsc_pkg::ST_RESP;
          endcase
        end
      end
      bfsc_pkg::ST_RMW: begin
        if (out_free) begin
          state_nxt = bfsc_pkg::ST_IDLE;
        end
      end
      bfsc_pkg::ST_FIND: begin
        if ((hit_any || scan_done) && out_free) begin
          state_nxt = bfsc_pkg::ST_IDLE;
        end
      end
      bfsc_pkg::ST_CLR: begin
        if (cur_r == CW'(n_words - CW'(1))) begin
          state_nxt = bfsc_pkg::ST_RESP;
        end
      end
      bfsc_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = bfsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfsc_pkg::ST_INIT;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_chan.ready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = AW'(cur_r);
    wr_en         = 1'b0;
    wr_addr       = AW'(cur_r);
    wr_data       = '0;
    load_out      = 1'b0;
    res_bit       = 1'b0;
    res_found     = 1'b0;
    res_idx       = '0;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    unique case (state_r)
      bfsc_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        cur_nxt = CW'(cur_r + CW'(1));
      end
      bfsc_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        rd_addr       = AW'(in_word);
        rd_en         = accept && in_hit &&
                        (in_chan.mode == bfsc_pkg::MODE_CHECK ||
                         in_chan.mode == bfsc_pkg::MODE_SET   ||
                         in_chan.mode == bfsc_pkg::MODE_CLEAR ||
                         in_chan.mode == bfsc_pkg::MODE_FIND);
        if (accept) begin
          cur_nxt  = (in_chan.mode == bfsc_pkg::MODE_CLEAR_ALL) ? '0 : {1'b0, in_word};
          step_nxt = CW'(1);
        end
      end
      bfsc_pkg::ST_RMW: begin
        load_out = out_free;
        res_bit  = (mode_r == bfsc_pkg::MODE_CHECK) ? rd_data_r[bit_r] : 1'b0;
        wr_en    = out_free &&
                   (mode_r == bfsc_pkg::MODE_SET || mode_r == bfsc_pkg::MODE_CLEAR);
        wr_data  = (mode_r == bfsc_pkg::MODE_SET) ? (rd_data_r | bit_mask)
                                                  : (rd_data_r & ~bit_mask);
      end
      bfsc_pkg::ST_FIND: begin
        priority if (hit_any) begin
          load_out  = out_free;
          res_found = 1'b1;
          res_idx   = {cur_r[bfsc_pkg::WSEL_W-1:0], bfsc_pkg::lowest_set(hits)};
        end else if (scan_done) begin
          load_out = out_free;
        end else begin
          // no match in this word: fetch the next one, wrapping at the count
          rd_en    = 1'b1;
          rd_addr  = AW'(next_word);
          cur_nxt  = next_word;
          step_nxt = CW'(step_r + CW'(1));
        end
      end
      bfsc_pkg::ST_CLR: begin
        wr_en   = 1'b1;
        cur_nxt = CW'(cur_r + CW'(1));
      end
      bfsc_pkg::ST_RESP: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfsc_pkg::ST_INIT;
      cur_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_chan.mode;
      bit_r  <= in_chan.bit_addr[BW-1:0];
      want_r <= in_chan.find_value;
    end
  end

  // ---------------------------------------------------------------- flag ram
  // read data holds while no read is issued, so a stalled answer stays put
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bit_r   <= res_bit;
      out_found_r <= res_found;
      out_idx_r   <= res_idx;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.bit_value   = out_bit_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.found_index = out_idx_r;

  // ---------------------------------------------------------------- checks
  a_found_no_bit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> !out_bit_r)
    else $error("find result carries a bit value");

  a_miss_zero_idx : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_idx_r == '0)
    else $error("not-found result has nonzero index");

  a_find_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfsc_pkg::ST_FIND |-> cur_r < n_words && step_r <= n_words)
    else $error("find walked past the words in use");

  a_no_load_over_full : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result word overwritten before taken");

  a_rmw_one_write : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfsc_pkg::ST_RMW && wr_en |=> state_r == bfsc_pkg::ST_IDLE)
    else $error("read-modify-write stayed after its write");

endmodule

/* bench/bitmap_find_set_clear_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_find_set_clear_test
// Self-checking bench for the bit-flag store with circular find. A shadow
// copy of the flag words and the word count predicts each result word,
// which is compared field by field with the block's output. The bench runs
// several word count settings and several idle and stall phases.
// ----------------------------------------------------------------------------
module bitmap_find_set_clear_test;
  import bfsc_pkg::*;

  localparam int STORE_WORDS      = 64;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int RANDOM_PHASES    = 9;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] bit_addr;
    logic               find_value;
  } flag_req_t;

  typedef struct packed {
    logic               bit_value;
    logic               found;
    logic [INDEX_W-1:0] found_index;
  } flag_resp_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [WCOUNT_W-1:0] cfg_wdata;

  bfsc_in_if  in_chan ();
  bfsc_out_if out_chan ();

  bitmap_find_set_clear #(
    .MAX_WORDS (STORE_WORDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  flag_word_t          flag_store [STORE_WORDS];
  logic [WCOUNT_W-1:0] word_count_shadow;
  flag_req_t           pending_requests [$];
  flag_resp_t          expected_responses [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_requests;
  int hold_off_served;
  int hold_off_left;
  int error_count;

  function automatic int words_in_use(logic [WCOUNT_W-1:0] wc);
    if (wc == 0) begin
      return 1;
    end
    if (wc > STORE_WORDS) begin
      return STORE_WORDS;
    end
    return int'(wc);
  endfunction

  // updates the shadow flag words and returns the result word
  function automatic flag_resp_t predict_response(flag_req_t r);
    flag_resp_t resp;
    flag_word_t hits;
    int         n;
    int         w;
    int         b;
    int         i;
    resp = '0;
    n    = words_in_use(word_count_shadow);
    w    = int'(r.bit_addr >> BIT_SEL_W);
    b    = int'(r.bit_addr[BIT_SEL_W-1:0]);
    case (r.mode)
      MODE_CHECK: begin
        if (w < n) begin
          resp.bit_value = flag_store[w][b];
        end
      end
      MODE_SET: begin
        if (w < n) begin
          flag_store[w][b] = 1'b1;
        end
      end
      MODE_CLEAR: begin
        if (w < n) begin
          flag_store[w][b] = 1'b0;
        end
      end
      MODE_FIND: begin
        // start word past the count never searches
        if (w < n) begin
          for (int k = 0; k < n && !resp.found; k++) begin
            i    = (w + k) % n;
            hits = r.find_value ? flag_store[i] : ~flag_store[i];
            if (hits != '0) begin
              resp.found = 1'b1;
              for (int j = WORD_BITS - 1; j >= 0; j--) begin
                if (hits[j]) begin
                  b = j;
                end
              end
              resp.found_index = INDEX_W'(i * WORD_BITS + b);
            end
          end
        end
      end
      MODE_CLEAR_ALL: begin
        for (int k = 0; k < n; k++) begin
          flag_store[k] = '0;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  function automatic flag_req_t random_request(int n);
    flag_req_t r;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.mode = MODE_W'($urandom_range(MODE_CLEAR_ALL + 1, 2 ** MODE_W - 1));
    end else if (roll < 8) begin
      r.mode = MODE_CLEAR_ALL;
    end else if (roll < 33) begin
      r.mode = MODE_CHECK;
    end else if (roll < 63) begin
      r.mode = MODE_SET;
    end else if (roll < 75) begin
      r.mode = MODE_CLEAR;
    end else begin
      r.mode = MODE_FIND;
    end
    // mostly inside the words in use, the rest anywhere
    if ($urandom_range(0, 99) < 85) begin
      r.bit_addr = {WSEL_W'($urandom_range(0, n - 1)), BIT_SEL_W'($urandom)};
    end else begin
      r.bit_addr = INDEX_W'($urandom);
    end
    r.find_value = 1'($urandom);
    return r;
  endfunction

  task automatic push_req(logic [MODE_W-1:0] mode, int bit_addr, bit find_value);
    flag_req_t r;
    r.mode       = mode;
    r.bit_addr   = INDEX_W'(bit_addr);
    r.find_value = find_value;
    pending_requests.push_back(r);
  endtask

  // fill one word, sometimes leaving one hole, then search it
  task automatic push_word_sweep(int w);
    int skip;
    skip = $urandom_range(0, 2 * WORD_BITS - 1);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (b != skip) begin
        push_req(MODE_SET, w * WORD_BITS + b, 1'b1);
      end
    end
    push_req(MODE_FIND, w * WORD_BITS, 1'b0);
    push_req(MODE_FIND, 0, 1'b0);
    push_req(MODE_FIND, 0, 1'b1);
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_requests.size() != 0 || in_chan.valid ||
               expected_responses.size() != 0 || !in_chan.ready);
  endtask

  task automatic write_word_count(logic [WCOUNT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // word count and request shadowing, sampled at the same edge as the block
  always @(posedge clk) begin : shadow_blk
    flag_req_t req;
    if (rst_n && cfg_we) begin
      word_count_shadow = cfg_wdata;
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      req.mode       = in_chan.mode;
      req.bit_addr   = in_chan.bit_addr;
      req.find_value = in_chan.find_value;
      expected_responses.push_back(predict_response(req));
    end
  end

  always @(posedge clk) begin : drive_blk
    flag_req_t next_req;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(1, 100) > sender_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_chan.valid      <= 1'b1;
        in_chan.mode       <= next_req.mode;
        in_chan.bit_addr   <= next_req.bit_addr;
        in_chan.find_value <= next_req.find_value;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else if (hold_off_served != hold_off_requests) begin
      out_chan.ready <= 1'b0;
      hold_off_left   = HOLD_OFF_CYCLES;
      hold_off_served = hold_off_served + 1;
    end else begin
      out_chan.ready <= ($urandom_range(1, 100) > receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : check_blk
    flag_resp_t got;
    flag_resp_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.bit_value   = out_chan.bit_value;
      got.found       = out_chan.found;
      got.found_index = out_chan.found_index;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected word: bit_value %0d found %0d found_index %0d",
                 $time, got.bit_value, got.found, got.found_index);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        if (got.bit_value !== want.bit_value) begin
          $display("%0t: bit_value expected %0d actual %0d",
                   $time, want.bit_value, got.bit_value);
          error_count++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          error_count++;
        end
        if (got.found_index !== want.found_index) begin
          $display("%0t: found_index expected %0d actual %0d",
                   $time, want.found_index, got.found_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("bitmap_find_set_clear_test failed");
    $finish;
  end

  initial begin : stim_blk
    logic [WCOUNT_W-1:0] count_plan [RANDOM_PHASES];
    logic [WCOUNT_W-1:0] wc;
    int                  n;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.mode       = '0;
    in_chan.bit_addr   = '0;
    in_chan.find_value = 1'b0;
    out_chan.ready     = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_requests  = 0;
    hold_off_served    = 0;
    hold_off_left      = 0;
    error_count        = 0;
    word_count_shadow  = WORD_COUNT_RESET;
    foreach (flag_store[k]) begin
      flag_store[k] = '0;
    end
    count_plan = '{7'd127, 7'd1, 7'd0, 7'd3, 7'd64, 7'd2, 7'd0, 7'd127, 7'd5};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // full store: extremes, wrap-around, no match, unused modes
    write_word_count(7'd64);
    push_req(MODE_CHECK, 0, 1'b0);
    push_req(MODE_SET, 0, 1'b0);
    push_req(MODE_SET, 4095, 1'b1);
    push_req(MODE_CHECK, 4095, 1'b0);
    push_req(MODE_CHECK, 0, 1'b1);
    push_req(MODE_FIND, 0, 1'b1);
    push_req(MODE_FIND, 4032, 1'b1);
    push_req(MODE_CLEAR, 4095, 1'b0);
    push_req(MODE_FIND, 4095, 1'b1);
    push_req(MODE_FIND, 0, 1'b0);
    push_req(MODE_CLEAR, 0, 1'b1);
    push_req(MODE_FIND, 100, 1'b1);
    push_req(MODE_SET, 4095, 1'b0);
    push_req(MODE_CLEAR_ALL, 4095, 1'b1);
    push_req(MODE_CHECK, 4095, 1'b1);
    for (int k = 1; k < 2 ** MODE_W - MODE_CLEAR_ALL; k++) begin
      push_req(MODE_W'(MODE_CLEAR_ALL + k), 4095, 1'b1);
    end
    wait_idle();

    // two words: accesses and find starts past the words in use
    write_word_count(7'd2);
    push_req(MODE_SET, 200, 1'b1);
    push_req(MODE_CHECK, 200, 1'b0);
    push_req(MODE_FIND, 128, 1'b0);
    push_req(MODE_SET, 127, 1'b0);
    push_req(MODE_FIND, 0, 1'b1);
    push_req(MODE_FIND, 4095, 1'b1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 54;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct    = 12;
          receiver_stall_pct = 12;
        end
      endcase
      wc = (p == 6) ? WCOUNT_W'($urandom_range(0, 127)) : count_plan[p];
      write_word_count(wc);
      n = words_in_use(wc);
      if (n <= 3) begin
        push_word_sweep($urandom_range(0, n - 1));
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        pending_requests.push_back(random_request(n));
      end
      // long receiver hold-off while requests keep coming
      if (p == 4) begin
        hold_off_requests = hold_off_requests + 1;
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("bitmap_find_set_clear_test passed");
    end else begin
      $display("bitmap_find_set_clear_test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bfsc_pkg.sv
src/bfsc_in_if.sv
src/bfsc_out_if.sv
src/bitmap_find_set_clear.sv
bench/bitmap_find_set_clear_test.sv
